FILE: rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Types, constants and opcode tables shared by the stack machine modules.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int MEM_WORDS   = 256;
    localparam int DW          = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int MA_W        = $clog2(MEM_WORDS);
    localparam int DEPTH_W     = 9;

    // opcodes
    localparam logic [4:0] OP_LIT   = 5'd0;
    localparam logic [4:0] OP_ADD   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_MUL   = 5'd3;
    localparam logic [4:0] OP_DIV   = 5'd4;
    localparam logic [4:0] OP_MOD   = 5'd5;
    localparam logic [4:0] OP_DUP   = 5'd6;
    localparam logic [4:0] OP_DROP  = 5'd7;
    localparam logic [4:0] OP_SWAP  = 5'd8;
    localparam logic [4:0] OP_OVER  = 5'd9;
    localparam logic [4:0] OP_ROT   = 5'd10;
    localparam logic [4:0] OP_NIP   = 5'd11;
    localparam logic [4:0] OP_TUCK  = 5'd12;
    localparam logic [4:0] OP_EQ    = 5'd13;
    localparam logic [4:0] OP_LT    = 5'd14;
    localparam logic [4:0] OP_GT    = 5'd15;
    localparam logic [4:0] OP_LE    = 5'd16;
    localparam logic [4:0] OP_GE    = 5'd17;
    localparam logic [4:0] OP_NE    = 5'd18;
    localparam logic [4:0] OP_AND   = 5'd19;
    localparam logic [4:0] OP_OR    = 5'd20;
    localparam logic [4:0] OP_NOT   = 5'd21;
    localparam logic [4:0] OP_STORE = 5'd22;
    localparam logic [4:0] OP_FETCH = 5'd23;
    localparam logic [4:0] OP_PRINT = 5'd24;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;

    typedef struct packed {
        logic [4:0]        req_type;
        logic signed [63:0] literal_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               printed_valid;
        logic signed [63:0] printed_value;
        logic [8:0]         depth;
        logic signed [63:0] top_value;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       latch_in;
        logic [1:0] rd_k;      // read stack entry count - rd_k
        logic       cap_t0;
        logic       cap_t1;
        logic       cap_t2;
        logic       eval;
        logic       md_start;
        logic       exec;
        logic       wr_push;
        logic       cap_top;
        logic       load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic is_md;
        logic md_done;
        logic push_more;
        logic out_free;
    } stat_t;

    function automatic logic [1:0] pop_cnt(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_LIT:                             n = 2'd0;
            OP_DUP, OP_DROP, OP_NOT,
            OP_FETCH, OP_PRINT:                 n = 2'd1;
            OP_ROT:                             n = 2'd3;
            default:                            n = (op > OP_PRINT) ? 2'd0 : 2'd2;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] push_cnt(input logic [4:0] op);
        logic [1:0] m;
        case (op)
            OP_DROP, OP_STORE, OP_PRINT:        m = 2'd0;
            OP_DUP, OP_SWAP:                    m = 2'd2;
            OP_OVER, OP_ROT, OP_TUCK:           m = 2'd3;
            default:                            m = (op > OP_PRINT) ? 2'd0 : 2'd1;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] flag(input logic c);
        return c ? {64{1'b1}} : 64'd0;
    endfunction

endpackage

FILE: rtl/sma_ram.sv
// ----------------------------------------------------------------------------
// sma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/sma_muldiv.sv
// ----------------------------------------------------------------------------
// sma_muldiv
// Shared multi-cycle unit: 64-bit wrapping multiply from three 32x32 partial
// products, or signed truncating divide / modulo, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sma_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_div,
    input  logic        want_rem,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    localparam int CW = $clog2(sma_pkg::DW);

    logic          busy_reg, busy_next;
    logic          fix_reg, fix_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          div_reg, rem_flag_reg, neg_q_reg, neg_r_reg;
    logic [63:0]   quo_reg, mb_reg, acc_reg, res_reg;
    logic [64:0]   rem_sh, diff;
    logic [31:0]   mx, my;
    logic [63:0]   prod;

    // restoring step
    assign rem_sh = {acc_reg, quo_reg[63]};
    assign diff   = rem_sh - {1'b0, mb_reg};

    // shared 32x32 multiplier
    always_comb
    begin
        mx = quo_reg[31:0];
        my = mb_reg[31:0];
        if (cnt_reg[1:0] == 2'd1)
        begin
            my = mb_reg[63:32];
        end
        else if (cnt_reg[1:0] == 2'd2)
        begin
            mx = quo_reg[63:32];
        end
    end
    assign prod = mx * my;

    // control
    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if ((div_reg && cnt_reg == CW'(sma_pkg::DW - 1)) ||
                (!div_reg && cnt_reg == CW'(2)))
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands, partial sums, sign fix
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg      <= is_div;
            rem_flag_reg <= want_rem;
            neg_q_reg    <= a[63] ^ b[63];
            neg_r_reg    <= a[63];
            acc_reg      <= '0;
            if (is_div)
            begin
                quo_reg <= a[63] ? (64'd0 - a) : a;
                mb_reg  <= b[63] ? (64'd0 - b) : b;
            end
            else
            begin
                quo_reg <= a;
                mb_reg  <= b;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                quo_reg <= {quo_reg[62:0], !diff[64]};
                acc_reg <= diff[64] ? rem_sh[63:0] : diff[63:0];
            end
            else if (cnt_reg[1:0] == 2'd0)
            begin
                acc_reg <= prod;
            end
            else
            begin
                acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
            end
        end
        else if (fix_reg)
        begin
            if (!div_reg)
            begin
                res_reg <= acc_reg;
            end
            else if (rem_flag_reg)
            begin
                res_reg <= neg_r_reg ? (64'd0 - acc_reg) : acc_reg;
            end
            else
            begin
                res_reg <= neg_q_reg ? (64'd0 - quo_reg) : quo_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/sma_datapath.sv
// ----------------------------------------------------------------------------
// sma_datapath
// Stack store, data memory, operand registers, checks, ALU, push sequencing
// and output register of the stack machine.
// ----------------------------------------------------------------------------
module sma_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sma_pkg::cmd_t      cmd,
    output sma_pkg::stat_t     stat,
    input  sma_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sma_pkg::out_item_t out_item
);

    localparam int CNT_W = sma_pkg::CNT_W;
    localparam int SP_W  = sma_pkg::SP_W;
    localparam int MA_W  = sma_pkg::MA_W;

    logic [4:0]       op_reg;
    logic [63:0]      lit_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [63:0]      t0_reg, t1_reg, t2_reg, top_reg;
    logic [2:0]       st_reg;
    logic [63:0]      res_reg [3];
    logic [1:0]       push_n_reg, push_idx_reg;
    logic [1:0]       rd_k_reg;
    logic             pvalid_reg;
    logic [63:0]      pval_reg;
    logic [sma_pkg::MEM_WORDS-1:0] dv_reg;
    logic             dv_hit_reg;
    logic             out_valid_reg;
    sma_pkg::out_item_t out_reg;

    logic [1:0]       n_pop, m_push;
    logic [2:0]       status;
    logic [CNT_W:0]   after;
    logic             is_md;
    logic [63:0]      alu [3];
    logic [63:0]      st_rdata, dm_rdata, md_result, fetch_val;
    logic             md_done;
    logic [SP_W-1:0]  st_raddr;
    logic             have_k;

    assign n_pop  = sma_pkg::pop_cnt(op_reg);
    assign m_push = sma_pkg::push_cnt(op_reg);
    assign is_md  = (op_reg == sma_pkg::OP_MUL) || (op_reg == sma_pkg::OP_DIV) ||
                    (op_reg == sma_pkg::OP_MOD);

    // stack store; read data is registered, so the presence check uses the
    // rd_k registered along with that address
    assign st_raddr = SP_W'(count_reg - CNT_W'(cmd.rd_k));
    assign have_k   = count_reg >= CNT_W'(rd_k_reg);

    sma_ram #(.WIDTH(64), .DEPTH(sma_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (cmd.wr_push),
        .waddr (count_reg[SP_W-1:0]),
        .wdata (res_reg[push_idx_reg]),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // data memory, unwritten words read as zero
    sma_ram #(.WIDTH(64), .DEPTH(sma_pkg::MEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (cmd.exec && op_reg == sma_pkg::OP_STORE),
        .waddr (t0_reg[MA_W-1:0]),
        .wdata (t1_reg),
        .raddr (t0_reg[MA_W-1:0]),
        .rdata (dm_rdata)
    );
    assign fetch_val = dv_hit_reg ? dm_rdata : 64'd0;

    sma_muldiv u_md (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.md_start),
        .is_div   (op_reg != sma_pkg::OP_MUL),
        .want_rem (op_reg == sma_pkg::OP_MOD),
        .a        (t1_reg),
        .b        (t0_reg),
        .done     (md_done),
        .result   (md_result)
    );

    // error checks
    always_comb
    begin
        after  = {1'b0, count_reg} - (CNT_W + 1)'(n_pop) + (CNT_W + 1)'(m_push);
        status = sma_pkg::ST_OK;
        if (op_reg == sma_pkg::OP_DIV || op_reg == sma_pkg::OP_MOD)
        begin
            if (count_reg == '0)
            begin
                status = sma_pkg::ST_UNDER;
            end
            else if (t0_reg == 64'd0)
            begin
                status = sma_pkg::ST_DIV0;
            end
            else if (count_reg < CNT_W'(2))
            begin
                status = sma_pkg::ST_UNDER;
            end
        end
        else if (count_reg < CNT_W'(n_pop))
        begin
            status = sma_pkg::ST_UNDER;
        end
        else if (after > (CNT_W + 1)'(sma_pkg::STACK_DEPTH))
        begin
            status = sma_pkg::ST_OVER;
        end
        if (status == sma_pkg::ST_OK &&
            (op_reg == sma_pkg::OP_STORE || op_reg == sma_pkg::OP_FETCH) &&
            t0_reg >= 64'(sma_pkg::MEM_WORDS))
        begin
            status = sma_pkg::ST_ADDR;
        end
    end

    // results, res[0] is pushed first
    always_comb
    begin
        alu[0] = 64'd0;
        alu[1] = 64'd0;
        alu[2] = 64'd0;
        case (op_reg)
            sma_pkg::OP_LIT:   alu[0] = lit_reg;
            sma_pkg::OP_ADD:   alu[0] = t1_reg + t0_reg;
            sma_pkg::OP_SUB:   alu[0] = t1_reg - t0_reg;
            sma_pkg::OP_MUL,
            sma_pkg::OP_DIV,
            sma_pkg::OP_MOD:   alu[0] = md_result;
            sma_pkg::OP_DUP:
            begin
                alu[0] = t0_reg;
                alu[1] = t0_reg;
            end
            sma_pkg::OP_SWAP:
            begin
                alu[0] = t0_reg;
                alu[1] = t1_reg;
            end
            sma_pkg::OP_OVER:
            begin
                alu[0] = t1_reg;
                alu[1] = t0_reg;
                alu[2] = t1_reg;
            end
            sma_pkg::OP_ROT:
            begin
                alu[0] = t1_reg;
                alu[1] = t0_reg;
                alu[2] = t2_reg;
            end
            sma_pkg::OP_NIP:   alu[0] = t0_reg;
            sma_pkg::OP_TUCK:
            begin
                alu[0] = t0_reg;
                alu[1] = t1_reg;
                alu[2] = t0_reg;
            end
            sma_pkg::OP_EQ:    alu[0] = sma_pkg::flag(t1_reg == t0_reg);
            sma_pkg::OP_LT:    alu[0] = sma_pkg::flag($signed(t1_reg) < $signed(t0_reg));
            sma_pkg::OP_GT:    alu[0] = sma_pkg::flag($signed(t0_reg) < $signed(t1_reg));
            sma_pkg::OP_LE:    alu[0] = sma_pkg::flag(!($signed(t0_reg) < $signed(t1_reg)));
            sma_pkg::OP_GE:    alu[0] = sma_pkg::flag(!($signed(t1_reg) < $signed(t0_reg)));
            sma_pkg::OP_NE:    alu[0] = sma_pkg::flag(t1_reg != t0_reg);
            sma_pkg::OP_AND:   alu[0] = t1_reg & t0_reg;
            sma_pkg::OP_OR:    alu[0] = t1_reg | t0_reg;
            sma_pkg::OP_NOT:   alu[0] = ~t0_reg;
            sma_pkg::OP_FETCH: alu[0] = fetch_val;
            default:           alu[0] = 64'd0;
        endcase
    end

    // stack count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.eval && status != sma_pkg::ST_OK)
        begin
            count_next = '0;
        end
        else if (cmd.exec)
        begin
            count_next = count_reg - CNT_W'(n_pop);
        end
        else if (cmd.wr_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
            push_n_reg    <= 2'd0;
            push_idx_reg  <= 2'd0;
            rd_k_reg      <= 2'd1;
        end
        else
        begin
            count_reg <= count_next;
            rd_k_reg  <= cmd.rd_k;
            if (cmd.exec && op_reg == sma_pkg::OP_STORE)
            begin
                dv_reg[t0_reg[MA_W-1:0]] <= 1'b1;
            end
            if (cmd.latch_in)
            begin
                push_n_reg   <= 2'd0;
                push_idx_reg <= 2'd0;
            end
            else if (cmd.exec)
            begin
                push_n_reg   <= m_push;
                push_idx_reg <= 2'd0;
            end
            else if (cmd.wr_push)
            begin
                push_idx_reg <= push_idx_reg + 2'd1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dv_hit_reg <= dv_reg[t0_reg[MA_W-1:0]];
        if (cmd.latch_in)
        begin
            op_reg     <= in_item.req_type;
            lit_reg    <= in_item.literal_value;
            pvalid_reg <= 1'b0;
            pval_reg   <= 64'd0;
            st_reg     <= sma_pkg::ST_OK;
        end
        if (cmd.cap_t0)
        begin
            t0_reg <= have_k ? st_rdata : 64'd0;
        end
        if (cmd.cap_t1)
        begin
            t1_reg <= have_k ? st_rdata : 64'd0;
        end
        if (cmd.cap_t2)
        begin
            t2_reg <= have_k ? st_rdata : 64'd0;
        end
        if (cmd.cap_top)
        begin
            top_reg <= have_k ? st_rdata : 64'd0;
        end
        if (cmd.eval)
        begin
            st_reg <= status;
        end
        if (cmd.exec)
        begin
            res_reg[0] <= alu[0];
            res_reg[1] <= alu[1];
            res_reg[2] <= alu[2];
            if (op_reg == sma_pkg::OP_PRINT)
            begin
                pvalid_reg <= 1'b1;
                pval_reg   <= t0_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_reg.status        <= st_reg;
            out_reg.printed_valid <= pvalid_reg;
            out_reg.printed_value <= pval_reg;
            out_reg.depth         <= sma_pkg::DEPTH_W'(count_reg);
            out_reg.top_value     <= top_reg;
        end
    end

    assign stat.err       = status != sma_pkg::ST_OK;
    assign stat.is_md     = is_md;
    assign stat.md_done   = md_done;
    assign stat.push_more = push_idx_reg != push_n_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: rtl/sma_ctrl.sv
// ----------------------------------------------------------------------------
// sma_ctrl
// Sequencer: operand reads, checks, execution, pushes, top read and result.
// ----------------------------------------------------------------------------
module sma_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output sma_pkg::cmd_t  cmd,
    input  sma_pkg::stat_t stat
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_MDW  = 4'd5;
    localparam logic [3:0] S_EXEC = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_TOP  = 4'd8;
    localparam logic [3:0] S_TOPD = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_k   = 2'd1;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_RD0;
                end
            end
            S_RD0:  state_next = S_RD1;
            S_RD1:
            begin
                // take t0, read the entry below it
                cmd.cap_t0 = 1'b1;
                cmd.rd_k   = 2'd2;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                // take t1, read t2
                cmd.cap_t1 = 1'b1;
                cmd.rd_k   = 2'd3;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.cap_t2 = 1'b1;
                cmd.eval   = 1'b1;
                if (stat.err)
                begin
                    state_next = S_TOP;
                end
                else if (stat.is_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = S_MDW;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_MDW:
            begin
                if (stat.md_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (stat.push_more)
                begin
                    cmd.wr_push = 1'b1;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:  state_next = S_TOPD;
            S_TOPD:
            begin
                cmd.cap_top = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/stack_machine_alu.sv
// Each item passes through operand reads, checks, execution, pushes, a top read
//   and the result; each further push lengthens it, and an error skips execution and pushes.
// Multiply uses three 32x32 partial products; divide and modulo produce
//   one quotient bit a cycle. One item in flight; the next is
//   accepted at the earliest in the cycle after the result is loaded.
// Reset: asynchronous, active low; empties the stack, marks memory words zero.
// ----------------------------------------------------------------------------
// stack_machine_alu
// Forth-style data stack machine with data memory and status reporting.
// ----------------------------------------------------------------------------
module stack_machine_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sma_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sma_pkg::out_item_t out_item
);

    sma_pkg::cmd_t  cmd;
    sma_pkg::stat_t stat;

    sma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sma_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: rtl/sma_checker.sv
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks on the stack machine result channel.
// ----------------------------------------------------------------------------
module sma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input sma_pkg::out_item_t out_item
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // an error empties the stack and prints nothing
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != sma_pkg::ST_OK |->
            out_item.depth == '0 && out_item.top_value == '0 && !out_item.printed_valid)
        else $error("error result not cleared");

    // no print means zero printed value
    a_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.printed_valid |-> out_item.printed_value == '0)
        else $error("stray printed value");

    // an empty stack shows zero on top
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.depth == '0 |-> out_item.top_value == '0)
        else $error("top value on empty stack");

endmodule

bind stack_machine_alu sma_checker u_sma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
